// ----- rtl/oneshot_periodic_timer_table_macros.svh -----
// Assertion macros shared by the checker of the timer table.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ONESHOT_PERIODIC_TIMER_TABLE_MACROS_SVH
`define ONESHOT_PERIODIC_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OPTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OPTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/optt_pkg.sv -----
// Package of the one-shot and periodic timer table: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package optt_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_W      = $clog2(TIMER_SLOTS);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int CMD_W       = 2;
	localparam int DELAY_W     = 24;
	localparam int ID_W        = 4;
	localparam int STATUS_W    = 3;
	localparam int NOW_W       = 32;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// Byte address of the enable register.
	localparam logic [PADDR_W-1:0] ADDR_ENABLE = PADDR_W'(0);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_ONESHOT,
		CMD_ADD_PERIODIC,
		CMD_CANCEL,
		CMD_TICK
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED,
		ST_ADD_FAIL,
		ST_CANCELED,
		ST_NOT_FOUND,
		ST_FIRED
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_RESP,
		S_TICK_SCAN,
		S_TICK_DRAIN,
		S_TICK_EMIT
	} state_t;

	typedef struct packed {
		logic enable;
		logic clear;
	} cfg_t;

	typedef struct packed {
		logic [DELAY_W-1:0] interval;
		logic [NOW_W-1:0]   expiry;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic idx_clr;
		logic idx_inc;
		logic arm;
		logic resp_load;
		logic scan_rd;
		logic fire_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t in_cmd;
		logic enabled;
		logic idx_last;
		logic slot_free;
		logic out_free;
		logic due_none;
		logic due_cur;
		logic due_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/oneshot_periodic_timer_table.sv -----
// Timer table top level; one request is worked at a time. A cancel goes straight to its
// result; an add first scans from slot zero for a free slot (no scan while disabled); a
// tick reads one expiry per slot, takes a drain step, then visits one slot per cycle, holding
// on a due slot while the result channel stalls, and loads one fired result per due slot. A
// tick while disabled gives no result. The next request waits until the last one is through,
// output stalls included. Reset clears enable, time and slots.
`default_nettype none

module oneshot_periodic_timer_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration port.
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [optt_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [optt_pkg::PDATA_W-1:0]   pwdata,
	output logic      [optt_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready,
	// Request channel.
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [optt_pkg::CMD_W-1:0]     cmd,
	input  wire logic [optt_pkg::DELAY_W-1:0]   delay_ms,
	input  wire logic [optt_pkg::ID_W-1:0]      timer_id,
	// Result channel.
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [optt_pkg::STATUS_W-1:0]  status,
	output logic      [optt_pkg::ID_W-1:0]      slot_id,
	output logic                                last
);

	// The enable register lives in the register file. Writing zero pulses a clear that
	// disarms every slot in the datapath at the same edge.
	optt_pkg::cfg_t     cfg;
	// The controller steers the datapath with one command word per cycle and watches
	// the status word the datapath returns.
	optt_pkg::dp_cmd_t  ctl;
	optt_pkg::dp_stat_t stat;

	optt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller only takes a request while idle. Add and cancel requests end in one
	// result; a tick first marks its due slots, rearming periodic slots and freeing one-shot
	// slots as they are found, and then sends one fired result per marked slot in slot order.
	optt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// The datapath holds the armed and periodic flags in flops, the interval and expiry of
	// each slot in a small memory, the millisecond counter and the output register that
	// decouples the result channel from the sequencing.
	optt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.delay_ms  (delay_ms),
		.timer_id  (timer_id),
		.cfg       (cfg),
		.ctl       (ctl),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (status),
		.slot_id   (slot_id),
		.last      (last)
	);

endmodule

`default_nettype wire

// ----- rtl/optt_regs.sv -----
// Configuration register file of the timer table: the enable register behind an APB port.
// Depends on optt_pkg.
`default_nettype none

module optt_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [optt_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [optt_pkg::PDATA_W-1:0]  pwdata,
	output logic      [optt_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output optt_pkg::cfg_t                     cfg
);

	logic enable_q;
	logic wr_enable;

	assign pready    = 1'b1;
	assign wr_enable = psel && penable && pwrite && (paddr == optt_pkg::ADDR_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (wr_enable) begin
			enable_q <= pwdata[0];
		end
	end

	// Writing zero disarms the whole table in the same cycle.
	assign cfg.enable = enable_q;
	assign cfg.clear  = wr_enable && !pwdata[0];

	assign prdata = (paddr == optt_pkg::ADDR_ENABLE) ?
		optt_pkg::PDATA_W'(enable_q) : '0;

endmodule

`default_nettype wire

// ----- rtl/optt_dp.sv -----
// Datapath of the timer table: slot flags, timer memory, tick counter and result register.
// Depends on optt_pkg; driven by optt_ctrl through dp_cmd_t.
`default_nettype none

module optt_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [optt_pkg::CMD_W-1:0]     cmd,
	input  wire logic [optt_pkg::DELAY_W-1:0]   delay_ms,
	input  wire logic [optt_pkg::ID_W-1:0]      timer_id,
	input  wire optt_pkg::cfg_t                 cfg,
	input  wire optt_pkg::dp_cmd_t              ctl,
	output optt_pkg::dp_stat_t                  stat,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic      [optt_pkg::STATUS_W-1:0]  status,
	output logic      [optt_pkg::ID_W-1:0]      slot_id,
	output logic                                last
);

	localparam int N = optt_pkg::TIMER_SLOTS;
	localparam int SW = optt_pkg::SLOT_W;

	// Control state.
	logic [optt_pkg::NOW_W-1:0] now_q;
	logic [N-1:0]               armed_q;
	logic [N-1:0]               periodic_q;
	logic [N-1:0]               due_q;
	logic [optt_pkg::CNT_W-1:0] cnt_q;
	logic                       found_q;
	logic [SW-1:0]              idx_q;
	logic                       scan_v_s1;
	logic                       out_valid_q;

	// Payload state.
	optt_pkg::cmd_t               cmd_q;
	logic [optt_pkg::DELAY_W-1:0] delay_q;
	logic [optt_pkg::ID_W-1:0]    id_q;
	logic [SW-1:0]                scan_idx_s1;
	optt_pkg::entry_t             ent_s1;
	optt_pkg::status_t            status_q;
	logic [optt_pkg::ID_W-1:0]    slot_q;
	logic                         last_q;

	optt_pkg::entry_t mem [N];

	logic                         wr_en;
	logic [SW-1:0]                wr_addr;
	optt_pkg::entry_t             wr_data;
	logic [optt_pkg::NOW_W-1:0]   diff;
	logic                         due_s1;
	logic                         arm_periodic;
	logic                         id_in_range;
	logic [SW-1:0]                id_sel;
	logic                         cancel_hit;
	logic                         is_add;
	optt_pkg::status_t            resp_status;
	logic [optt_pkg::ID_W-1:0]    resp_slot;
	logic [N-1:0]                 due_others;

	assign diff   = ent_s1.expiry - now_q;
	assign due_s1 = scan_v_s1 && armed_q[scan_idx_s1]
		&& ((diff == '0) || diff[optt_pkg::NOW_W-1])
		&& (cnt_q < optt_pkg::CNT_W'(optt_pkg::MAX_RESULTS));

	assign arm_periodic = (cmd_q == optt_pkg::CMD_ADD_PERIODIC) && (delay_q != '0);

	assign id_in_range = (32'(id_q) < N);
	assign id_sel      = SW'(id_q);
	assign cancel_hit  = (cmd_q == optt_pkg::CMD_CANCEL) && cfg.enable && id_in_range
		&& armed_q[id_sel];
	assign is_add      = (cmd_q == optt_pkg::CMD_ADD_ONESHOT)
		|| (cmd_q == optt_pkg::CMD_ADD_PERIODIC);

	always_comb begin
		if (is_add) begin
			resp_status = found_q ? optt_pkg::ST_ADDED : optt_pkg::ST_ADD_FAIL;
			resp_slot   = found_q ? optt_pkg::ID_W'(idx_q) : '0;
		end else begin
			resp_status = cancel_hit ? optt_pkg::ST_CANCELED : optt_pkg::ST_NOT_FOUND;
			resp_slot   = id_q;
		end
	end

	assign due_others = due_q & ~(N'(1) << idx_q);

	// Arming writes the new entry; a due periodic slot rewrites its expiry.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '{interval: delay_q, expiry: now_q + optt_pkg::NOW_W'(delay_q)};
		priority if (ctl.arm) begin
			wr_en = 1'b1;
		end else if (due_s1 && periodic_q[scan_idx_s1]) begin
			wr_en   = 1'b1;
			wr_addr = scan_idx_s1;
			wr_data = '{interval: ent_s1.interval,
				expiry: now_q + optt_pkg::NOW_W'(ent_s1.interval)};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.scan_rd) begin
			ent_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			armed_q     <= '0;
			periodic_q  <= '0;
			due_q       <= '0;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_v_s1 <= ctl.scan_rd;
			if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + SW'(1);
			end
			if (ctl.accept) begin
				found_q <= 1'b0;
				due_q   <= '0;
				cnt_q   <= '0;
				if ((optt_pkg::cmd_t'(cmd) == optt_pkg::CMD_TICK) && cfg.enable) begin
					now_q <= now_q + optt_pkg::NOW_W'(1);
				end
			end
			if (ctl.arm) begin
				found_q             <= 1'b1;
				armed_q[idx_q]      <= 1'b1;
				periodic_q[idx_q]   <= arm_periodic;
			end
			if (due_s1) begin
				due_q[scan_idx_s1] <= 1'b1;
				cnt_q              <= cnt_q + optt_pkg::CNT_W'(1);
				if (!periodic_q[scan_idx_s1]) begin
					armed_q[scan_idx_s1] <= 1'b0;
				end
			end
			if (ctl.resp_load && cancel_hit) begin
				armed_q[id_sel]    <= 1'b0;
				periodic_q[id_sel] <= 1'b0;
			end
			if (ctl.fire_load) begin
				due_q[idx_q] <= 1'b0;
			end
			if (cfg.clear) begin
				armed_q    <= '0;
				periodic_q <= '0;
			end
			if (ctl.resp_load || ctl.fire_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= optt_pkg::cmd_t'(cmd);
			delay_q <= delay_ms;
			id_q    <= timer_id;
		end
		if (ctl.scan_rd) begin
			scan_idx_s1 <= idx_q;
		end
		if (ctl.resp_load) begin
			status_q <= resp_status;
			slot_q   <= resp_slot;
			last_q   <= 1'b1;
		end else if (ctl.fire_load) begin
			status_q <= optt_pkg::ST_FIRED;
			slot_q   <= optt_pkg::ID_W'(idx_q);
			last_q   <= (due_others == '0);
		end
	end

	assign stat.in_cmd    = optt_pkg::cmd_t'(cmd);
	assign stat.enabled   = cfg.enable;
	assign stat.idx_last  = (idx_q == SW'(N - 1));
	assign stat.slot_free = !armed_q[idx_q];
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.due_none  = (due_q == '0);
	assign stat.due_cur   = due_q[idx_q];
	assign stat.due_last  = (due_others == '0);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot_id   = slot_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ----- rtl/optt_ctrl.sv -----
// Controller of the timer table: sequences add scans, responses and the two tick sweeps.
// Depends on optt_pkg; commands optt_dp through dp_cmd_t.
`default_nettype none

module optt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire optt_pkg::dp_stat_t stat,
	output optt_pkg::dp_cmd_t       ctl
);

	optt_pkg::state_t state_q;
	optt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= optt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			optt_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (stat.in_cmd)
						optt_pkg::CMD_ADD_ONESHOT,
						optt_pkg::CMD_ADD_PERIODIC: begin
							state_d = stat.enabled ? optt_pkg::S_ADD_SCAN : optt_pkg::S_RESP;
						end
						optt_pkg::CMD_CANCEL: begin
							state_d = optt_pkg::S_RESP;
						end
						optt_pkg::CMD_TICK: begin
							state_d = stat.enabled ? optt_pkg::S_TICK_SCAN : optt_pkg::S_IDLE;
						end
						default: begin
							state_d = optt_pkg::S_IDLE;
						end
					endcase
				end
			end
			optt_pkg::S_ADD_SCAN: begin
				if (stat.slot_free || stat.idx_last) begin
					state_d = optt_pkg::S_RESP;
				end
			end
			optt_pkg::S_RESP: begin
				if (stat.out_free) begin
					state_d = optt_pkg::S_IDLE;
				end
			end
			optt_pkg::S_TICK_SCAN: begin
				if (stat.idx_last) begin
					state_d = optt_pkg::S_TICK_DRAIN;
				end
			end
			optt_pkg::S_TICK_DRAIN: begin
				state_d = optt_pkg::S_TICK_EMIT;
			end
			optt_pkg::S_TICK_EMIT: begin
				if (stat.due_none) begin
					state_d = optt_pkg::S_IDLE;
				end else if (stat.due_cur && stat.out_free && stat.due_last) begin
					state_d = optt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = optt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			optt_pkg::S_IDLE: begin
				ctl.accept  = in_valid;
				ctl.idx_clr = 1'b1;
			end
			optt_pkg::S_ADD_SCAN: begin
				if (stat.slot_free) begin
					ctl.arm = 1'b1;
				end else if (!stat.idx_last) begin
					ctl.idx_inc = 1'b1;
				end
			end
			optt_pkg::S_RESP: begin
				ctl.resp_load = stat.out_free;
			end
			optt_pkg::S_TICK_SCAN: begin
				ctl.scan_rd = 1'b1;
				ctl.idx_inc = !stat.idx_last;
			end
			optt_pkg::S_TICK_DRAIN: begin
				ctl.idx_clr = 1'b1;
			end
			optt_pkg::S_TICK_EMIT: begin
				if (!stat.due_none) begin
					if (stat.due_cur) begin
						if (stat.out_free) begin
							ctl.fire_load = 1'b1;
							ctl.idx_inc   = !stat.due_last;
						end
					end else begin
						ctl.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	assign in_ready = (state_q == optt_pkg::S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/optt_checker.sv -----
// Port-level checker of the timer table, bound to the top level.
// Depends on optt_pkg and the assertion macros header.
`default_nettype none

`include "oneshot_periodic_timer_table_macros.svh"

module optt_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [optt_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [optt_pkg::PDATA_W-1:0]   pwdata,
	input  wire logic [optt_pkg::PDATA_W-1:0]   prdata,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic [optt_pkg::CMD_W-1:0]     cmd,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [optt_pkg::STATUS_W-1:0]  status,
	input  wire logic [optt_pkg::ID_W-1:0]      slot_id,
	input  wire logic                           last
);

	// An add or cancel request always owes a result, so the block cannot be idle right after.
	`OPTT_ASSERT_NEXT(a_cmd_busy, in_valid && in_ready && (cmd != optt_pkg::CMD_TICK), !in_ready, "request channel ready right after an add or cancel")

	// The enable register reads back what was written.
	`OPTT_ASSERT_NEXT(a_enable_rb, psel && penable && pwrite && (paddr == optt_pkg::ADDR_ENABLE), (paddr != optt_pkg::ADDR_ENABLE) || (prdata[0] == $past(pwdata[0])), "enable register does not read back the written value")

	// A stalled result holds.
	`OPTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot_id) && $stable(last), "stalled result changed")

	// A failed add names slot zero and ends its request.
	`OPTT_ASSERT_NOW(a_fail_slot, out_valid && (status == optt_pkg::ST_ADD_FAIL), (slot_id == '0) && last, "failed add without slot zero or last")

endmodule

bind oneshot_periodic_timer_table optt_checker u_optt_checker (.*);

`default_nettype wire
